>>> rtl/core/dlfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_pkg
// Shared widths, codes and saturation helpers for the dense layer engine.
// ----------------------------------------------------------------------------
package dlfb_pkg;

  localparam int unsigned MAX_FEATURES = 64;
  localparam int unsigned MAX_NEURONS  = 64;
  localparam int unsigned MAX_BATCH    = 32;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned SMP_W   = 5;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned RES_W   = 32;
  localparam int unsigned CNT_W   = 7;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned CFG_D_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_W  = 3'd0,
    OP_LOAD_B  = 3'd1,
    OP_FWD     = 3'd2,
    OP_BWD     = 3'd3,
    OP_RD_W    = 3'd4,
    OP_RD_B    = 3'd5,
    OP_ADJ_ROW = 3'd6,
    OP_ADJ_COL = 3'd7
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FWD = 2'd0,
    KIND_DX  = 2'd1,
    KIND_DW  = 2'd2,
    KIND_DB  = 2'd3
  } kind_e;

  typedef enum logic [CFG_A_W-1:0] {
    REG_FEATURE_COUNT = 3'd0,
    REG_NEURON_COUNT  = 3'd1,
    REG_WEIGHT_L1     = 3'd2,
    REG_WEIGHT_L2     = 3'd3,
    REG_BIAS_L1       = 3'd4,
    REG_BIAS_L2       = 3'd5
  } cfg_reg_e;

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[VAL_W-1:0];
  endfunction

  function automatic logic signed [RES_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 48'sd2147483647) return 32'sh7fffffff;
    if (v < -48'sd2147483648) return 32'sh80000000;
    return v[RES_W-1:0];
  endfunction

endpackage

>>> rtl/core/dlfb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_if
// Handshake channels: input items, result items and configuration writes.
// ----------------------------------------------------------------------------
interface dlfb_item_if;
  import dlfb_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [SMP_W-1:0]   sample;
  logic [IDX_W-1:0]   feature;
  logic [IDX_W-1:0]   neuron;
  logic signed [VAL_W-1:0] value_in;
  logic               last_in;
  modport source (output valid, opcode, sample, feature, neuron, value_in, last_in,
                  input ready);
  modport sink   (input valid, opcode, sample, feature, neuron, value_in, last_in,
                  output ready);
endinterface

interface dlfb_result_if;
  import dlfb_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic [IDX_W-1:0]   result_index;
  logic signed [RES_W-1:0] result_value;
  logic               last_out;
  modport source (output valid, result_kind, result_index, result_value, last_out,
                  input ready);
  modport sink   (input valid, result_kind, result_index, result_value, last_out,
                  output ready);
endinterface

interface dlfb_cfg_if;
  import dlfb_pkg::*;
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] index;
  logic [CFG_D_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/dlfb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlfb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dlfb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/dense_layer_forward_backward_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_layer_forward_backward_top
// Dense layer engine, forward and backward, Q4.12 data, Q16.16 gradients.
//
// Sequencing: one item at a time, input held off until the sequencer is idle.
//   Loads and read-free ops finish on accept; reads step through the read,
//   multiply and emit states, and each emit can stall on result ready.
//   Forward last item: read, multiply, accumulate per feature, one emit per neuron.
//   Backward last item: the same per neuron, one emit per feature; sample 0 first
//   seeds the full MaxFeatures*MaxNeurons grid. Adjust ops: the same per entry.
// Reset: counts go to 64, coefficients to 0; the weight and bias gradient
//   memories are then cleared with input held off.
// ----------------------------------------------------------------------------
module dense_layer_forward_backward_top #(
  parameter int unsigned MaxFeatures = dlfb_pkg::MAX_FEATURES,
  parameter int unsigned MaxNeurons  = dlfb_pkg::MAX_NEURONS,
  parameter int unsigned MaxBatch    = dlfb_pkg::MAX_BATCH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dlfb_item_if.sink      item_i,
  dlfb_result_if.source  result_o,
  dlfb_cfg_if.sink       cfg_i
);
  import dlfb_pkg::*;

  localparam int unsigned FIW = (MaxFeatures > 1) ? $clog2(MaxFeatures) : 1;
  localparam int unsigned NIW = (MaxNeurons > 1) ? $clog2(MaxNeurons) : 1;
  localparam int unsigned SBW = (MaxBatch > 1) ? $clog2(MaxBatch) : 1;
  localparam int unsigned WDEPTH = MaxFeatures * MaxNeurons;
  localparam int unsigned XDEPTH = MaxBatch * MaxFeatures;
  localparam int unsigned WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int unsigned XAW = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
  localparam int unsigned FLIM = (MaxFeatures < 64) ? MaxFeatures : 64;
  localparam int unsigned NLIM = (MaxNeurons < 64) ? MaxNeurons : 64;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RD, ST_MUL, ST_ACC, ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MD_FWD, MD_BWD, MD_SEED, MD_ADJ_ROW, MD_ADJ_COL, MD_RD_W, MD_RD_B
  } mode_e;

  // Configuration registers
  logic [CNT_W-1:0] feat_cnt_q, neur_cnt_q;
  logic [VAL_W-1:0] wl1_q, wl2_q, bl1_q, bl2_q;

  // Sequencer state
  state_e state_q;
  mode_e  mode_q;
  logic [FIW-1:0] ci_q;
  logic [NIW-1:0] cj_q;
  logic [SBW-1:0] sample_q;
  logic signed [VAL_W-1:0] val_q;
  logic rdz_q;
  logic [IDX_W-1:0] idx_q;

  // Datapath registers
  logic signed [33:0] prod_a_q, prod_b_q;
  logic signed [RES_W-1:0] wg_q, bg_q;
  logic signed [VAL_W-1:0] g_q, wdat_q, bdat_q;
  logic signed [ACC_W-1:0] acc_q;

  // Output register
  logic out_valid_q;
  logic [KIND_W-1:0] out_kind_q;
  logic [IDX_W-1:0] out_idx_q;
  logic signed [RES_W-1:0] out_val_q;
  logic out_last_q;

  // Memory ports
  logic w_we, b_we, x_we, g_we, wg_we, bg_we;
  logic [WAW-1:0] w_waddr, wg_waddr, w_raddr;
  logic [NIW-1:0] b_waddr, g_waddr, bg_waddr;
  logic [XAW-1:0] x_waddr, x_raddr;
  logic [VAL_W-1:0] w_wdata, b_wdata, x_wdata, g_wdata;
  logic [RES_W-1:0] wg_wdata, bg_wdata;
  logic signed [VAL_W-1:0] w_rd, b_rd, x_rd, g_rd;
  logic signed [RES_W-1:0] wg_rd, bg_rd;

  dlfb_ram #(.Width(VAL_W), .Depth(WDEPTH)) u_w_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rd));
  dlfb_ram #(.Width(VAL_W), .Depth(MaxNeurons)) u_b_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(cj_q), .rdata_o(b_rd));
  dlfb_ram #(.Width(VAL_W), .Depth(XDEPTH)) u_x_ram (
    .clk_i, .we_i(x_we), .waddr_i(x_waddr), .wdata_i(x_wdata),
    .raddr_i(x_raddr), .rdata_o(x_rd));
  dlfb_ram #(.Width(VAL_W), .Depth(MaxNeurons)) u_g_ram (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i(cj_q), .rdata_o(g_rd));
  dlfb_ram #(.Width(RES_W), .Depth(WDEPTH)) u_wg_ram (
    .clk_i, .we_i(wg_we), .waddr_i(wg_waddr), .wdata_i(wg_wdata),
    .raddr_i(w_raddr), .rdata_o(wg_rd));
  dlfb_ram #(.Width(RES_W), .Depth(MaxNeurons)) u_bg_ram (
    .clk_i, .we_i(bg_we), .waddr_i(bg_waddr), .wdata_i(bg_wdata),
    .raddr_i(cj_q), .rdata_o(bg_rd));

  // Clamp counts to 1..limit
  logic [CNT_W-1:0] nf_eff, nn_eff, f_last, n_last;
  always_comb begin
    nf_eff = feat_cnt_q;
    if (feat_cnt_q == '0) nf_eff = CNT_W'(1);
    else if (32'(feat_cnt_q) > FLIM) nf_eff = CNT_W'(FLIM);
    nn_eff = neur_cnt_q;
    if (neur_cnt_q == '0) nn_eff = CNT_W'(1);
    else if (32'(neur_cnt_q) > NLIM) nn_eff = CNT_W'(NLIM);
    f_last = nf_eff - CNT_W'(1);
    n_last = nn_eff - CNT_W'(1);
  end

  logic accept, fok, nok, s_ok;
  logic ci_at_f, cj_at_n, ci_at_max, cj_at_max;
  logic [WAW-1:0] cur_waddr, in_waddr;
  opcode_e op;

  assign accept    = item_i.valid && item_i.ready;
  assign op        = opcode_e'(item_i.opcode);
  assign fok       = CNT_W'(item_i.feature) < nf_eff;
  assign nok       = CNT_W'(item_i.neuron) < nn_eff;
  assign s_ok      = 32'(item_i.sample) < MaxBatch;
  assign ci_at_f   = 9'(ci_q) == 9'(f_last);
  assign cj_at_n   = 9'(cj_q) == 9'(n_last);
  assign ci_at_max = ci_q == FIW'(MaxFeatures - 1);
  assign cj_at_max = cj_q == NIW'(MaxNeurons - 1);
  assign cur_waddr = WAW'(32'(ci_q) * MaxNeurons + 32'(cj_q));
  assign in_waddr  = WAW'(32'(item_i.feature) * MaxNeurons + 32'(item_i.neuron));
  assign w_raddr   = cur_waddr;
  assign x_raddr   = XAW'(32'(sample_q) * MaxFeatures + 32'(ci_q));

  // Arithmetic for the write-back step
  logic signed [ACC_W-1:0] acc_next, wg_upd, bg_upd, w_seed_sum, b_seed_sum;
  logic signed [RES_W-1:0] w_seed, b_seed;
  logic signed [VAL_W-1:0] w_adj;
  logic in_use_w, in_use_b;

  always_comb begin
    acc_next = ACC_W'(prod_a_q);
    if (mode_q == MD_FWD && ci_q == '0) begin
      acc_next = (ACC_W'(bdat_q) <<< 12) + ACC_W'(prod_a_q);
    end else if (!(mode_q == MD_BWD && cj_q == '0)) begin
      acc_next = acc_q + ACC_W'(prod_a_q);
    end
    wg_upd = ACC_W'(wg_q) + ((ACC_W'(prod_b_q) + 48'sd128) >>> 8);
    bg_upd = ACC_W'(bg_q) + (ACC_W'(g_q) <<< 4);
    // Seed: signed L1 term plus rounded 2*L2*coefficient
    w_seed_sum = ((ACC_W'(prod_a_q) + 48'sd128) >>> 8);
    if (wdat_q[VAL_W-1]) w_seed_sum = w_seed_sum - ACC_W'({wl1_q, 4'b0});
    else                 w_seed_sum = w_seed_sum + ACC_W'({wl1_q, 4'b0});
    b_seed_sum = ((ACC_W'(prod_b_q) + 48'sd128) >>> 8);
    if (bdat_q[VAL_W-1]) b_seed_sum = b_seed_sum - ACC_W'({bl1_q, 4'b0});
    else                 b_seed_sum = b_seed_sum + ACC_W'({bl1_q, 4'b0});
    in_use_w = (9'(ci_q) <= 9'(f_last)) && (9'(cj_q) <= 9'(n_last));
    in_use_b = 9'(cj_q) <= 9'(n_last);
    w_seed   = in_use_w ? sat32(w_seed_sum) : '0;
    b_seed   = in_use_b ? sat32(b_seed_sum) : '0;
    w_adj    = sat16(ACC_W'(wdat_q) + ACC_W'(val_q));
  end

  // Memory write control
  always_comb begin
    w_we = 1'b0; w_waddr = in_waddr; w_wdata = item_i.value_in;
    b_we = 1'b0; b_waddr = NIW'(item_i.neuron); b_wdata = item_i.value_in;
    x_we = 1'b0; x_wdata = item_i.value_in;
    x_waddr = XAW'(32'(item_i.sample) * MaxFeatures + 32'(item_i.feature));
    g_we = 1'b0; g_waddr = NIW'(item_i.neuron); g_wdata = item_i.value_in;
    wg_we = 1'b0; wg_waddr = cur_waddr; wg_wdata = '0;
    bg_we = 1'b0; bg_waddr = cj_q; bg_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        wg_we = 1'b1;
        bg_we = (ci_q == '0);
      end
      ST_IDLE: begin
        if (accept) begin
          w_we = (op == OP_LOAD_W) && fok && nok;
          b_we = (op == OP_LOAD_B) && nok;
          x_we = (op == OP_FWD) && s_ok && fok;
          g_we = (op == OP_BWD) && s_ok && nok;
        end
      end
      ST_ACC: begin
        case (mode_q)
          MD_ADJ_ROW, MD_ADJ_COL: begin
            w_we = 1'b1; w_waddr = cur_waddr; w_wdata = w_adj;
          end
          MD_SEED: begin
            wg_we = 1'b1; wg_wdata = w_seed;
            bg_we = (ci_q == '0); bg_wdata = b_seed;
          end
          MD_BWD: begin
            wg_we = 1'b1; wg_wdata = sat32(wg_upd);
            bg_we = (ci_q == '0); bg_wdata = sat32(bg_upd);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Result formation
  logic [KIND_W-1:0] emit_kind;
  logic [IDX_W-1:0] emit_idx;
  logic signed [RES_W-1:0] emit_val;
  logic emit_last;
  always_comb begin
    emit_kind = KIND_FWD;
    emit_idx  = IDX_W'(cj_q);
    emit_val  = RES_W'(sat16((acc_q + 48'sd2048) >>> 12));
    emit_last = cj_at_n;
    case (mode_q)
      MD_BWD: begin
        emit_kind = KIND_DX;
        emit_idx  = IDX_W'(ci_q);
        emit_val  = sat32((acc_q + 48'sd128) >>> 8);
        emit_last = ci_at_f;
      end
      MD_RD_W: begin
        emit_kind = KIND_DW; emit_idx = idx_q;
        emit_val = rdz_q ? '0 : wg_q; emit_last = 1'b1;
      end
      MD_RD_B: begin
        emit_kind = KIND_DB; emit_idx = idx_q;
        emit_val = rdz_q ? '0 : bg_q; emit_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign item_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign result_o.valid        = out_valid_q;
  assign result_o.result_kind  = out_kind_q;
  assign result_o.result_index = out_idx_q;
  assign result_o.result_value = out_val_q;
  assign result_o.last_out     = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_cnt_q <= CNT_W'(64); neur_cnt_q <= CNT_W'(64);
      wl1_q <= '0; wl2_q <= '0; bl1_q <= '0; bl2_q <= '0;
      state_q <= ST_CLEAR; mode_q <= MD_FWD;
      ci_q <= '0; cj_q <= '0; sample_q <= '0; val_q <= '0;
      rdz_q <= 1'b0; idx_q <= '0;
      prod_a_q <= '0; prod_b_q <= '0; wg_q <= '0; bg_q <= '0;
      g_q <= '0; wdat_q <= '0; bdat_q <= '0; acc_q <= '0;
      out_valid_q <= 1'b0; out_kind_q <= '0; out_idx_q <= '0;
      out_val_q <= '0; out_last_q <= 1'b0;
    end else begin
      // Register writes
      if (cfg_i.valid) begin
        unique case (cfg_reg_e'(cfg_i.index))
          REG_FEATURE_COUNT: feat_cnt_q <= cfg_i.data[CNT_W-1:0];
          REG_NEURON_COUNT:  neur_cnt_q <= cfg_i.data[CNT_W-1:0];
          REG_WEIGHT_L1:     wl1_q <= cfg_i.data;
          REG_WEIGHT_L2:     wl2_q <= cfg_i.data;
          REG_BIAS_L1:       bl1_q <= cfg_i.data;
          REG_BIAS_L2:       bl2_q <= cfg_i.data;
          default: ;
        endcase
      end

      // Drop a result once taken; the emit state handles its own beat
      if (result_o.ready && state_q != ST_EMIT) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_CLEAR: begin
          // Sweep every gradient entry to zero
          if (cj_at_max) begin
            cj_q <= '0;
            if (ci_at_max) begin
              ci_q <= '0;
              state_q <= ST_IDLE;
            end else begin
              ci_q <= ci_q + FIW'(1);
            end
          end else begin
            cj_q <= cj_q + NIW'(1);
          end
        end

        ST_IDLE: begin
          if (accept) begin
            val_q    <= item_i.value_in;
            sample_q <= SBW'(item_i.sample);
            idx_q    <= item_i.neuron;
            unique case (op)
              OP_FWD: begin
                if (s_ok && item_i.last_in) begin
                  mode_q <= MD_FWD; ci_q <= '0; cj_q <= '0; state_q <= ST_RD;
                end
              end
              OP_BWD: begin
                if (s_ok && item_i.last_in) begin
                  // Sample 0 reseeds the gradients before accumulating
                  mode_q <= (item_i.sample == '0) ? MD_SEED : MD_BWD;
                  ci_q <= '0; cj_q <= '0; state_q <= ST_RD;
                end
              end
              OP_RD_W: begin
                mode_q <= MD_RD_W;
                rdz_q  <= !(fok && nok);
                ci_q   <= fok ? FIW'(item_i.feature) : '0;
                cj_q   <= nok ? NIW'(item_i.neuron) : '0;
                state_q <= ST_RD;
              end
              OP_RD_B: begin
                mode_q <= MD_RD_B;
                rdz_q  <= !nok;
                cj_q   <= nok ? NIW'(item_i.neuron) : '0;
                state_q <= ST_RD;
              end
              OP_ADJ_ROW: begin
                if (fok) begin
                  mode_q <= MD_ADJ_ROW; ci_q <= FIW'(item_i.feature); cj_q <= '0;
                  state_q <= ST_RD;
                end
              end
              OP_ADJ_COL: begin
                if (nok) begin
                  mode_q <= MD_ADJ_COL; ci_q <= '0; cj_q <= NIW'(item_i.neuron);
                  state_q <= ST_RD;
                end
              end
              default: ;
            endcase
          end
        end

        ST_RD: state_q <= ST_MUL;

        ST_MUL: begin
          // Capture read data and form the products
          wg_q <= wg_rd; bg_q <= bg_rd; g_q <= g_rd;
          wdat_q <= w_rd;
          if (mode_q == MD_FWD) begin
            if (ci_q == '0) bdat_q <= b_rd;
          end else begin
            bdat_q <= b_rd;
          end
          case (mode_q)
            MD_FWD: prod_a_q <= 34'(x_rd * w_rd);
            MD_BWD: begin
              prod_a_q <= 34'(g_rd * w_rd);
              prod_b_q <= 34'(x_rd * g_rd);
            end
            MD_SEED: begin
              prod_a_q <= 34'($signed({1'b0, wl2_q, 1'b0}) * w_rd);
              prod_b_q <= 34'($signed({1'b0, bl2_q, 1'b0}) * b_rd);
            end
            default: ;
          endcase
          state_q <= (mode_q == MD_RD_W || mode_q == MD_RD_B) ? ST_EMIT : ST_ACC;
        end

        ST_ACC: begin
          acc_q <= acc_next;
          case (mode_q)
            MD_FWD: begin
              if (ci_at_f) begin
                state_q <= ST_EMIT;
              end else begin
                ci_q <= ci_q + FIW'(1);
                state_q <= ST_RD;
              end
            end
            MD_BWD: begin
              if (cj_at_n) begin
                state_q <= ST_EMIT;
              end else begin
                cj_q <= cj_q + NIW'(1);
                state_q <= ST_RD;
              end
            end
            MD_SEED: begin
              state_q <= ST_RD;
              if (cj_at_max) begin
                cj_q <= '0;
                if (ci_at_max) begin
                  ci_q <= '0;
                  mode_q <= MD_BWD;
                end else begin
                  ci_q <= ci_q + FIW'(1);
                end
              end else begin
                cj_q <= cj_q + NIW'(1);
              end
            end
            MD_ADJ_ROW: begin
              if (cj_at_n) begin
                state_q <= ST_IDLE;
              end else begin
                cj_q <= cj_q + NIW'(1);
                state_q <= ST_RD;
              end
            end
            MD_ADJ_COL: begin
              if (ci_at_f) begin
                state_q <= ST_IDLE;
              end else begin
                ci_q <= ci_q + FIW'(1);
                state_q <= ST_RD;
              end
            end
            default: state_q <= ST_IDLE;
          endcase
        end

        ST_EMIT: begin
          // Hold until the output register is free
          if (!out_valid_q || result_o.ready) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= emit_kind;
            out_idx_q   <= emit_idx;
            out_val_q   <= emit_val;
            out_last_q  <= emit_last;
            case (mode_q)
              MD_FWD: begin
                ci_q <= '0;
                if (cj_at_n) begin
                  state_q <= ST_IDLE;
                end else begin
                  cj_q <= cj_q + NIW'(1);
                  state_q <= ST_RD;
                end
              end
              MD_BWD: begin
                cj_q <= '0;
                if (ci_at_f) begin
                  state_q <= ST_IDLE;
                end else begin
                  ci_q <= ci_q + FIW'(1);
                  state_q <= ST_RD;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
